>>> hdl/bfth_pkg.sv
// Package for the three-hash Bloom filter.
// Holds the shared widths, reset values and the hash bundle type.
// No dependencies.
`default_nettype none

package bfth_pkg;

    localparam int HASH_W          = 32;
    localparam int CNT_W           = 5;
    localparam int BYTE_W          = 8;
    localparam int SIZE_W          = 17;
    localparam int FILTER_BITS_DEF = 65536;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;
    localparam logic [HASH_W-1:0] DJB_SEED   = 32'd5381;
    localparam logic [HASH_W-1:0] SDBM_SEED  = 32'd0;
    localparam logic [HASH_W-1:0] POLY_SEED  = 32'd0;

    typedef struct packed {
        logic [HASH_W-1:0] djb;
        logic [HASH_W-1:0] sdbm;
        logic [HASH_W-1:0] poly;
    } t_hashes;

endpackage

`default_nettype wire

>>> hdl/bfth_hash.sv
// Running hash registers of the Bloom filter: djb2, sdbm and times-31.
// Depends on bfth_pkg.
`default_nettype none

module bfth_hash
    import bfth_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_update,
    input  wire logic              i_seed,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_hashes                o_hashes
);

    localparam int DJB_SHIFT   = 5;
    localparam int SDBM_SHIFT1 = 6;
    localparam int SDBM_SHIFT2 = 16;
    localparam int POLY_SHIFT  = 5;

    t_hashes r_h;
    t_hashes n_h;
    logic [HASH_W-1:0] w_byte;

    assign w_byte = HASH_W'(i_byte);

    always_comb begin
        n_h = r_h;
        if (i_seed) begin
            n_h.djb  = DJB_SEED;
            n_h.sdbm = SDBM_SEED;
            n_h.poly = POLY_SEED;
        end else if (i_update) begin
            n_h.djb  = (r_h.djb << DJB_SHIFT) + r_h.djb + w_byte;
            n_h.sdbm = w_byte + (r_h.sdbm << SDBM_SHIFT1) + (r_h.sdbm << SDBM_SHIFT2)
                       - r_h.sdbm;
            n_h.poly = (r_h.poly << POLY_SHIFT) - r_h.poly + w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h.djb  <= DJB_SEED;
            r_h.sdbm <= SDBM_SEED;
            r_h.poly <= POLY_SEED;
        end else begin
            r_h <= n_h;
        end
    end

    assign o_hashes = r_h;

endmodule

`default_nettype wire

>>> hdl/bfth_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Reduces a 32-bit hash modulo the effective filter size. Depends on bfth_pkg.
`default_nettype none

module bfth_mod
    import bfth_pkg::*;
#(
    parameter int AW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    input  wire logic [AW:0]       i_divisor,
    output logic                   o_done,
    output logic [AW-1:0]          o_rem
);

    localparam int SW = AW + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    logic [HASH_W-1:0] r_dvd;
    logic [SW-1:0]     r_div;
    logic [SW-1:0]     r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SW:0]       w_sh;
    logic [SW:0]       w_diff;

    assign w_sh   = {r_rem, r_dvd[HASH_W-1]};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            if (w_sh >= {1'b0, r_div}) begin
                r_rem <= w_diff[SW-1:0];
            end else begin
                r_rem <= w_sh[SW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

`default_nettype wire

>>> hdl/bfth_bitmem.sv
// One-bit-wide filter bit store with a clearing sweep after reset.
// Read data is registered; no package dependency.
`default_nettype none

module bfth_bitmem #(
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_set,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    output logic                          o_rdata,
    output logic                          o_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    logic          r_mem [DEPTH];
    logic          r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == ADDR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr] <= 1'b0;
        end else if (i_set) begin
            r_mem[i_addr] <= 1'b1;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

`default_nettype wire

>>> hdl/bloom_filter_three_hash.sv
// Top level of the three-hash Bloom filter: sequencer, size register and outputs.
// Depends on bfth_pkg, bfth_hash, bfth_mod and bfth_bitmem.
//
// Usage: a record enters one byte per transaction. A transaction is taken on a
// rising edge with i_start high and o_busy low; i_opcode, i_record_byte and
// i_last_byte travel with it. A byte without i_last_byte only updates the three
// running hashes, so o_busy stays low. On the last byte each hash is reduced
// modulo the filter size by one shared restoring remainder unit, and the
// addressed bit is set (insert) or read (check) in a one-bit-wide memory.
// o_done rises once all three hashes are handled, with o_busy high until then.
// o_done is high for a single cycle; o_was_check and o_maybe_present hold until
// the next result. The receiver cannot stall, and the next byte may enter in the
// o_done cycle. i_cfg_we writes i_cfg_wdata into the filter size register at
// once; write it only while o_busy is low. A record in progress keeps its hashes
// and uses the new size at its last byte. Sizes of zero act as one and sizes
// above FILTER_BITS act as FILTER_BITS. After reset o_busy stays high while the
// bit store is cleared one entry per cycle; the size register resets to 65536.
`default_nettype none

module bloom_filter_three_hash
    import bfth_pkg::*;
#(
    parameter int FILTER_BITS = FILTER_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_opcode,
    input  wire logic [BYTE_W-1:0] i_record_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    output logic                   o_done,
    output logic                   o_was_check,
    output logic                   o_maybe_present
);

    localparam int AW = $clog2(FILTER_BITS);
    localparam int SW = AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;

    localparam logic [1:0] K_DJB  = 2'd0;
    localparam logic [1:0] K_SDBM = 2'd1;
    localparam logic [1:0] K_POLY = 2'd2;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_k, n_k;
    logic              r_op, n_op;
    logic              r_hit, n_hit;
    logic              r_done, n_done;
    logic              r_was_check, n_was_check;
    logic              r_maybe, n_maybe;
    logic [SIZE_W-1:0] r_size;

    logic              w_accept;
    logic              w_seed;
    logic              w_div_done;
    logic [AW-1:0]     w_rem;
    logic              w_rdata;
    logic              w_mem_ready;
    logic [HASH_W-1:0] w_dividend;
    logic [31:0]       w_size_ext;
    logic [31:0]       w_eff32;
    logic [SW-1:0]     w_eff;
    t_hashes           w_hashes;

    assign w_accept = i_start && !o_busy;
    assign w_seed   = (r_state == S_RDW) && (r_k == K_POLY);

    assign w_size_ext = 32'(r_size);
    always_comb begin
        if (r_size == '0) begin
            w_eff32 = 32'd1;
        end else if (w_size_ext > 32'(FILTER_BITS)) begin
            w_eff32 = 32'(FILTER_BITS);
        end else begin
            w_eff32 = w_size_ext;
        end
    end
    assign w_eff = w_eff32[SW-1:0];

    always_comb begin
        unique case (r_k)
            K_DJB:   w_dividend = w_hashes.djb;
            K_SDBM:  w_dividend = w_hashes.sdbm;
            K_POLY:  w_dividend = w_hashes.poly;
            default: w_dividend = w_hashes.djb;
        endcase
    end

    bfth_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_accept),
        .i_seed   (w_seed),
        .i_byte   (i_record_byte),
        .o_hashes (w_hashes)
    );

    bfth_mod #(
        .AW (AW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_dividend),
        .i_divisor  (w_eff),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    bfth_bitmem #(
        .DEPTH (FILTER_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_set   ((r_state == S_ACC) && !r_op),
        .i_addr  (w_rem),
        .o_rdata (w_rdata),
        .o_ready (w_mem_ready)
    );

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_op        = r_op;
        n_hit       = r_hit;
        n_done      = 1'b0;
        n_was_check = r_was_check;
        n_maybe     = r_maybe;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_last_byte) begin
                    n_op    = i_opcode;
                    n_k     = K_DJB;
                    n_hit   = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_hit = r_hit && w_rdata;
                if (r_k == K_POLY) begin
                    n_done      = 1'b1;
                    n_was_check = r_op;
                    n_maybe     = r_op && r_hit && w_rdata;
                    n_state     = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= K_DJB;
            r_done  <= 1'b0;
            r_size  <= SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_hit       <= n_hit;
        r_was_check <= n_was_check;
        r_maybe     <= n_maybe;
    end

    assign o_busy          = (r_state != S_IDLE) || !w_mem_ready;
    assign o_done          = r_done;
    assign o_was_check     = r_was_check;
    assign o_maybe_present = r_maybe;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_RDW) && ($past(r_k) == K_POLY))
        else $error("result issued before all three hashes were handled");

    a_acc_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> $past(w_div_done))
        else $error("bit access started without a finished remainder");

endmodule

`default_nettype wire

>>> dv/bfth_checker.sv
// Scoreboard for the three-hash Bloom filter testbench: predicts every lookup result
// from the byte and size-write transactions it observes and compares the outputs.
// Depends on bfth_pkg.
`default_nettype none

module bfth_checker
    import bfth_pkg::*;
#(
    parameter int FILTER_BITS = FILTER_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic              i_opcode,
    input  wire logic [BYTE_W-1:0] i_record_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    input  wire logic              i_done,
    input  wire logic              i_was_check,
    input  wire logic              i_maybe_present,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic was_check;
        logic maybe_present;
    } t_lookup;

    logic              filter_mem [FILTER_BITS];
    t_hashes           acc;
    logic [SIZE_W-1:0] size_reg;
    t_lookup           lookup_q [$];
    int                fail_cnt = 0;

    function automatic logic [HASH_W-1:0] fold(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] span;
        span = HASH_W'(size_reg);
        if (span == '0) begin
            span = HASH_W'(1);
        end
        if (span > HASH_W'(FILTER_BITS)) begin
            span = HASH_W'(FILTER_BITS);
        end
        return h % span;
    endfunction

    function automatic void match_field(input string name, input logic exp, input logic act);
        if (act !== exp) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp, act);
            fail_cnt++;
        end
    endfunction

    task automatic take_byte();
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] p1;
        logic [HASH_W-1:0] p2;
        logic [HASH_W-1:0] p3;
        t_lookup           res;
        b        = {{(HASH_W-BYTE_W){1'b0}}, i_record_byte};
        acc.djb  = (acc.djb << 5) + acc.djb + b;
        acc.sdbm = b + (acc.sdbm << 6) + (acc.sdbm << 16) - acc.sdbm;
        acc.poly = acc.poly * 31 + b;
        if (i_last_byte) begin
            p1 = fold(acc.djb);
            p2 = fold(acc.sdbm);
            p3 = fold(acc.poly);
            res.was_check     = i_opcode;
            res.maybe_present = 1'b0;
            if (i_opcode) begin
                res.maybe_present = filter_mem[p1] & filter_mem[p2] & filter_mem[p3];
            end else begin
                filter_mem[p1] = 1'b1;
                filter_mem[p2] = 1'b1;
                filter_mem[p3] = 1'b1;
            end
            lookup_q.push_back(res);
            acc = {DJB_SEED, SDBM_SEED, POLY_SEED};
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup exp;
        if (!i_rst_n) begin
            foreach (filter_mem[k]) begin
                filter_mem[k] = 1'b0;
            end
            acc      = {DJB_SEED, SDBM_SEED, POLY_SEED};
            size_reg = SIZE_RESET;
            lookup_q.delete();
        end else begin
            if (i_cfg_we) begin
                size_reg = i_cfg_wdata;
            end
            if (i_done) begin
                if (lookup_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0b/%0b",
                             $time, i_was_check, i_maybe_present);
                    fail_cnt++;
                end else begin
                    exp = lookup_q.pop_front();
                    match_field("was_check", exp.was_check, i_was_check);
                    match_field("maybe_present", exp.maybe_present, i_maybe_present);
                end
            end
            if (i_start && !i_busy) begin
                take_byte();
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= lookup_q.size();
    end

endmodule

`default_nettype wire

>>> dv/tb.sv
// Top of the three-hash Bloom filter testbench: clock, reset, record and size-write
// stimulus, and the final verdict. Depends on bfth_pkg, bloom_filter_three_hash
// and bfth_checker.
`default_nettype none

module tb;
    import bfth_pkg::*;

    localparam logic OP_INSERT     = 1'b0;
    localparam logic OP_CHECK      = 1'b1;
    localparam int   ITEM_TARGET   = 1550;
    localparam int   SETTLE_CYCLES = 150;
    localparam int   LIB_DEPTH     = 32;
    localparam int   MAX_LEN       = 8;
    localparam int   PLAN_LEN      = 10;
    localparam int   CFG_SPACING   = 150;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic              i_opcode;
    logic [BYTE_W-1:0] i_record_byte;
    logic              i_last_byte;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;
    logic              o_done;
    logic              o_was_check;
    logic              o_maybe_present;
    int                fail_count;
    int                pending;

    int                idle_pct;
    int                items_sent;
    int                lib_cnt;
    logic [BYTE_W-1:0] lib_bytes [LIB_DEPTH][MAX_LEN];
    int                lib_len [LIB_DEPTH];
    logic [BYTE_W-1:0] rec [MAX_LEN];
    logic [SIZE_W-1:0] size_plan [PLAN_LEN];

    bloom_filter_three_hash u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_opcode        (i_opcode),
        .i_record_byte   (i_record_byte),
        .i_last_byte     (i_last_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_was_check     (o_was_check),
        .o_maybe_present (o_maybe_present)
    );

    bfth_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_opcode        (i_opcode),
        .i_record_byte   (i_record_byte),
        .i_last_byte     (i_last_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_done          (o_done),
        .i_was_check     (o_was_check),
        .i_maybe_present (o_maybe_present),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input logic op, input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_opcode      <= op;
        i_record_byte <= b;
        i_last_byte   <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        items_sent++;
    endtask

    // Stops issuing bytes until every pending lookup has come back and the
    // block has had time to finish any work on the last record.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_record(input logic op, input int len, input logic mixed);
        logic byte_op;
        for (int k = 0; k < len; k++) begin
            byte_op = (mixed && k < len - 1) ? logic'($urandom_range(1)) : op;
            send_byte(byte_op, rec[k], k == len - 1);
        end
    endtask

    task automatic random_record();
        int   choice;
        int   len;
        int   slot;
        logic op;
        choice = $urandom_range(99);
        op     = $urandom_range(1) ? OP_CHECK : OP_INSERT;
        if (choice < 25 && lib_cnt > 0) begin
            // Replay a record that was inserted earlier so checks can hit.
            slot = $urandom_range(lib_cnt - 1);
            len  = lib_len[slot];
            for (int k = 0; k < len; k++) begin
                rec[k] = lib_bytes[slot][k];
            end
            send_record(op, len, 1'b0);
        end else begin
            len = $urandom_range(MAX_LEN, 1);
            for (int k = 0; k < len; k++) begin
                rec[k] = BYTE_W'($urandom_range(255));
            end
            send_record(op, len, choice >= 90);
            if (op == OP_INSERT) begin
                if (lib_cnt < LIB_DEPTH) begin
                    slot = lib_cnt;
                    lib_cnt++;
                end else begin
                    slot = $urandom_range(LIB_DEPTH - 1);
                end
                lib_len[slot] = len;
                for (int k = 0; k < len; k++) begin
                    lib_bytes[slot][k] = rec[k];
                end
            end
        end
    endtask

    initial begin
        int next_cfg;
        int plan_idx;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_opcode      <= OP_INSERT;
        i_record_byte <= '0;
        i_last_byte   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        idle_pct   = 29;
        items_sent = 0;
        lib_cnt    = 0;
        plan_idx   = 0;
        size_plan  = '{17'd3, 17'd64, 17'd1000, 17'd65535, SIZE_RESET,
                       17'd100000, 17'd0, 17'd8, 17'd257, 17'd2};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(OP_INSERT, 8'hFF, 1'b1);
        send_byte(OP_CHECK, 8'hFF, 1'b1);
        send_byte(OP_CHECK, 8'h01, 1'b1);
        // Only the opcode on the last byte decides the record type.
        send_byte(OP_CHECK, 8'h00, 1'b0);
        send_byte(OP_INSERT, 8'h80, 1'b0);
        send_byte(OP_INSERT, 8'h7F, 1'b1);
        send_byte(OP_CHECK, 8'h00, 1'b0);
        send_byte(OP_CHECK, 8'h80, 1'b0);
        send_byte(OP_CHECK, 8'h7F, 1'b1);
        send_byte(OP_CHECK, 8'h00, 1'b1);
        // The size changes in the middle of a record and applies at its last byte.
        send_byte(OP_INSERT, 8'h55, 1'b0);
        send_byte(OP_INSERT, 8'hAA, 1'b0);
        write_size(17'd13);
        send_byte(OP_INSERT, 8'h01, 1'b1);
        send_byte(OP_CHECK, 8'h55, 1'b0);
        send_byte(OP_CHECK, 8'hAA, 1'b0);
        send_byte(OP_CHECK, 8'h01, 1'b1);
        write_size('0);
        send_byte(OP_INSERT, 8'h12, 1'b1);
        send_byte(OP_CHECK, 8'h34, 1'b1);
        write_size('1);
        send_byte(OP_CHECK, 8'hFF, 1'b1);
        send_byte(OP_CHECK, 8'hFE, 1'b1);
        write_size(17'd1);
        send_byte(OP_CHECK, 8'hC3, 1'b1);

        next_cfg = items_sent + CFG_SPACING;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent < 540) begin
                idle_pct = 29;
            end else if (items_sent < 1040) begin
                idle_pct = 71;
            end else begin
                idle_pct = 0;
            end
            if (items_sent >= next_cfg) begin
                write_size(plan_idx < PLAN_LEN ? size_plan[plan_idx] :
                           SIZE_W'($urandom_range(300, 1)));
                plan_idx++;
                next_cfg = items_sent + CFG_SPACING;
            end
            random_record();
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
